// ===== rtl/lsu3_pkg.sv =====
`default_nettype none
package lsu3_pkg;

	// Field and register widths.
	localparam int SIZE_W     = 9;
	localparam int PHI_W      = 24;
	localparam int STEP_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Defaults for the top-level parameters and the registers.
	localparam int DEF_MAX_SIZE_X = 256;
	localparam int DEF_MAX_SIZE_Y = 256;
	localparam int DEF_MAX_SIZE_Z = 256;
	localparam int DEF_SIZE       = 256;
	localparam int DEF_TIME_STEP  = 2048;
	localparam int SIZE_LIMIT     = (1 << SIZE_W) - 1;

	// Arithmetic widths of the datapath.
	localparam int STEP_FRAC_BITS = 12;
	localparam int DIFF_W         = PHI_W + 1;
	localparam int TERM_W         = 2 * PHI_W + 1;
	localparam int PSUM_W         = TERM_W + 1;
	localparam int SUM_W          = 52;
	localparam int ROOT_W         = SUM_W / 2;
	localparam int REM_W          = ROOT_W + 3;
	localparam int PROD_W         = ROOT_W + STEP_W;
	localparam int V_W            = PROD_W + 2;
	localparam int Q_W            = V_W - STEP_FRAC_BITS;
	localparam int SQRT_STEPS     = 2;
	localparam int SQRT_STAGES    = ROOT_W / SQRT_STEPS;

	localparam logic signed [PHI_W-1:0] PHI_MAX = {1'b0, {(PHI_W-1){1'b1}}};
	localparam logic signed [PHI_W-1:0] PHI_MIN = {1'b1, {(PHI_W-1){1'b0}}};

	// Neighbor slots; even slots are the backward neighbors.
	localparam int NB    = 6;
	localparam int NB_XM = 0;
	localparam int NB_XP = 1;
	localparam int NB_YM = 2;
	localparam int NB_YP = 3;
	localparam int NB_ZM = 4;
	localparam int NB_ZP = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X    = 3'd0,
		REG_SIZE_Y    = 3'd1,
		REG_SIZE_Z    = 3'd2,
		REG_TIME_STEP = 3'd3,
		REG_FRONT_DIR = 3'd4
	} cfg_reg_t;

	// Side data that travels with a voxel through the root pipeline.
	typedef struct packed {
		logic signed [PHI_W-1:0] centre;
		logic                    last;
	} pay_t;

	// Working state of the restoring square root.
	typedef struct packed {
		logic [SUM_W-1:0]  val;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	// One restoring step: brings in two radicand bits, yields one root bit.
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		sqrt_state_t n;
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		rem_sh = {s.rem[REM_W-3:0], s.val[SUM_W-1 -: 2]};
		trial  = REM_W'({s.root, 2'b01});
		n.val  = {s.val[SUM_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			n.rem  = rem_sh - trial;
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = rem_sh;
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lsu3_delay.sv =====
`default_nettype none
// Programmable delay line in a circular buffer. After a push, dout shows the
// value pushed len pushes ago; a length of zero passes din straight through.
module lsu3_delay #(
	parameter int ADDR_W = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [ADDR_W:0]           len,
	input  wire logic [lsu3_pkg::PHI_W-1:0] din,
	output logic      [lsu3_pkg::PHI_W-1:0] dout
);

	logic [lsu3_pkg::PHI_W-1:0] mem [2**ADDR_W];
	logic [ADDR_W-1:0]          wp_q;
	logic [ADDR_W-1:0]          rd_addr;
	logic [lsu3_pkg::PHI_W-1:0] rd_q;

	// The entry read was written len-1 pushes ago; rd_q adds the last one.
	assign rd_addr = wp_q - ADDR_W'(len - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (push) begin
			wp_q <= wp_q + 1'b1;
		end
	end

	// Buffer write and registered read.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= din;
			rd_q      <= (len == (ADDR_W+1)'(1)) ? din : mem[rd_addr];
		end
	end

	assign dout = (len == '0) ? din : rd_q;

endmodule
`default_nettype wire

// ===== rtl/lsu3_isqrt.sv =====
`default_nettype none
// Pipelined integer square root, truncated, two root bits per stage.
module lsu3_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lsu3_pkg::SUM_W-1:0]    in_radicand,
	input  wire lsu3_pkg::pay_t                in_pay,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lsu3_pkg::ROOT_W-1:0]   out_root,
	output lsu3_pkg::pay_t                     out_pay
);

	localparam int NST = lsu3_pkg::SQRT_STAGES;

	lsu3_pkg::sqrt_state_t st_s  [NST];
	lsu3_pkg::pay_t        pay_s [NST];
	logic [NST-1:0]        vld_s;
	logic [NST:0]          rdy;

	assign rdy[NST]  = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NST-1];
	assign out_root  = st_s[NST-1].root;
	assign out_pay   = pay_s[NST-1];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		lsu3_pkg::sqrt_state_t src;
		lsu3_pkg::sqrt_state_t nxt;
		lsu3_pkg::pay_t        src_pay;
		logic                  src_vld;

		// Stage input comes from the port or from the previous stage.
		if (k == 0) begin : g_first
			always_comb begin
				src.val  = in_radicand;
				src.rem  = '0;
				src.root = '0;
				src_pay  = in_pay;
				src_vld  = in_valid;
			end
		end else begin : g_next
			always_comb begin
				src     = st_s[k-1];
				src_pay = pay_s[k-1];
				src_vld = vld_s[k-1];
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_comb begin
			nxt = src;
			for (int i = 0; i < lsu3_pkg::SQRT_STEPS; i++) begin
				nxt = lsu3_pkg::sqrt_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_vld) begin
				st_s[k]  <= nxt;
				pay_s[k] <= src_pay;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/level_set_upwind_update_3d_core.sv =====
`default_nettype none
// One explicit upwind level-set step over a 3-D volume of Q15.8 voxels that
// arrive in raster order. Unless stalled, the block accepts one voxel and
// returns one updated voxel per cycle, also in raster order; the first
// result follows one slice plus one voxel behind the input, and drain items
// push out the last slice after the volume is complete. Each result passes
// 19 register stages (four for differences, squares and sums, thirteen for
// the square root, one for the time-step product, one for rounding and
// saturation). A single-slice volume adds an input-free step after its final
// voxel, and the cycle after any configuration write takes no input. The
// neighbor window lives in four delay-line memories of about two slices in
// total, one write and one read per voxel, and needs no clearing after reset.
module level_set_upwind_update_3d_core #(
	parameter int MAX_SIZE_X = lsu3_pkg::DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y = lsu3_pkg::DEF_MAX_SIZE_Y,
	parameter int MAX_SIZE_Z = lsu3_pkg::DEF_MAX_SIZE_Z
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [lsu3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lsu3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [lsu3_pkg::PHI_W-1:0]  phi_value,
	input  wire logic                               drain,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [lsu3_pkg::PHI_W-1:0]       new_phi,
	output logic                                    clipped,
	output logic                                    last_voxel
);

	localparam int SW  = lsu3_pkg::SIZE_W;
	localparam int PW  = lsu3_pkg::PHI_W;
	localparam int NB  = lsu3_pkg::NB;
	localparam int MAXX_E = (MAX_SIZE_X > lsu3_pkg::SIZE_LIMIT) ? lsu3_pkg::SIZE_LIMIT : MAX_SIZE_X;
	localparam int MAXY_E = (MAX_SIZE_Y > lsu3_pkg::SIZE_LIMIT) ? lsu3_pkg::SIZE_LIMIT : MAX_SIZE_Y;
	localparam int MAXZ_E = (MAX_SIZE_Z > lsu3_pkg::SIZE_LIMIT) ? lsu3_pkg::SIZE_LIMIT : MAX_SIZE_Z;
	localparam int RSTX   = (MAXX_E < lsu3_pkg::DEF_SIZE) ? MAXX_E : lsu3_pkg::DEF_SIZE;
	localparam int RSTY   = (MAXY_E < lsu3_pkg::DEF_SIZE) ? MAXY_E : lsu3_pkg::DEF_SIZE;
	localparam int RSTZ   = (MAXZ_E < lsu3_pkg::DEF_SIZE) ? MAXZ_E : lsu3_pkg::DEF_SIZE;
	localparam int ADDR_A_W = $clog2(MAXX_E * MAXY_E);
	localparam int ADDR_B_W = $clog2(MAXX_E);

	function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v, input logic [SW-1:0] mx);
		if (v == '0) begin
			return SW'(1);
		end
		if (v > mx) begin
			return mx;
		end
		return v;
	endfunction

	// Configuration and volume bookkeeping.
	logic [SW-1:0]                  sx_q, sy_q, sz_q;
	logic [lsu3_pkg::STEP_W-1:0]    tstep_q;
	logic                           dir_q;
	logic                           cfg_busy_q;
	logic [ADDR_A_W:0]              len_a_q;
	logic [ADDR_B_W:0]              len_b_q;
	logic [2*SW-1:0]                slice_rows;
	logic [SW-1:0]                  rx_q, ry_q, rz_q;
	logic [SW-1:0]                  ex_q, ey_q, ez_q;
	logic                           full_q, extra_q;

	// Window taps.
	logic [PW-1:0] head, t_a, t_b, t_c, t_d;
	logic [PW-1:0] tap_c_q, tap_xm_q;

	logic acc, real_push, dummy_push, push, emit, set_extra, extra_fire;
	logic r_last, e_last, size_wr;

	// Pipeline stages.
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                          s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;
	logic signed [PW-1:0]          c_s1, c_s2, c_s3, c_s4;
	logic signed [PW-1:0]          nb_s1 [NB];
	logic [NB-1:0]                 inb_s1;
	logic                          dir_s1;
	logic                          last_s1, last_s2, last_s3, last_s4;
	logic [lsu3_pkg::TERM_W-1:0]   term_s2 [NB];
	logic [lsu3_pkg::TERM_W-1:0]   term_d  [NB];
	logic [lsu3_pkg::PSUM_W-1:0]   psum_s3 [NB/2];
	logic [lsu3_pkg::SUM_W-1:0]    sum_s4;
	lsu3_pkg::pay_t                sq_in_pay, sq_out_pay, pay_s5;
	logic                          sq_in_rdy, sq_out_vld;
	logic [lsu3_pkg::ROOT_W-1:0]   sq_root;
	logic [lsu3_pkg::PROD_W-1:0]   prod_s5;
	logic signed [lsu3_pkg::V_W-1:0] v_full;
	logic [lsu3_pkg::Q_W-1:0]      q_full;
	logic                          q_ovf;
	logic signed [PW-1:0]          new_phi_s6;
	logic                          clipped_s6, last_s6;

	// Input side: a real voxel, a drain-phase step or the extra step that a
	// single-slice volume needs once its last voxel has arrived.
	assign in_ready   = s1_rdy && !cfg_busy_q && !extra_q;
	assign acc        = in_valid && in_ready;
	assign real_push  = acc && !drain && !full_q;
	assign extra_fire = extra_q && s1_rdy;
	assign dummy_push = (acc && full_q) || extra_fire;
	assign push       = real_push || dummy_push;
	assign head       = real_push ? phi_value : '0;
	assign r_last     = (rx_q == sx_q - 1'b1) && (ry_q == sy_q - 1'b1) && (rz_q == sz_q - 1'b1);
	assign e_last     = (ex_q == sx_q - 1'b1) && (ey_q == sy_q - 1'b1) && (ez_q == sz_q - 1'b1);
	assign emit       = (real_push && (rz_q != '0)) || dummy_push;
	assign set_extra  = real_push && r_last && (rz_q == '0);
	assign size_wr    = cfg_write && ((cfg_index == lsu3_pkg::REG_SIZE_X) ||
		(cfg_index == lsu3_pkg::REG_SIZE_Y) || (cfg_index == lsu3_pkg::REG_SIZE_Z));
	assign slice_rows = (2*SW)'(sx_q) * (2*SW)'(sy_q - 1'b1);

	// Configuration registers and delay lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q       <= SW'(RSTX);
			sy_q       <= SW'(RSTY);
			sz_q       <= SW'(RSTZ);
			tstep_q    <= lsu3_pkg::STEP_W'(lsu3_pkg::DEF_TIME_STEP);
			dir_q      <= 1'b0;
			cfg_busy_q <= 1'b0;
			len_a_q    <= '0;
			len_b_q    <= '0;
		end else begin
			cfg_busy_q <= cfg_write;
			len_a_q    <= (ADDR_A_W+1)'(slice_rows);
			len_b_q    <= (ADDR_B_W+1)'(sx_q - 1'b1);
			if (cfg_write) begin
				case (cfg_index)
					lsu3_pkg::REG_SIZE_X: begin
						sx_q <= clamp_size(cfg_data[SW-1:0], SW'(MAXX_E));
					end
					lsu3_pkg::REG_SIZE_Y: begin
						sy_q <= clamp_size(cfg_data[SW-1:0], SW'(MAXY_E));
					end
					lsu3_pkg::REG_SIZE_Z: begin
						sz_q <= clamp_size(cfg_data[SW-1:0], SW'(MAXZ_E));
					end
					lsu3_pkg::REG_TIME_STEP: begin
						tstep_q <= cfg_data;
					end
					lsu3_pkg::REG_FRONT_DIR: begin
						dir_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Receive and emit positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q    <= '0;
			ry_q    <= '0;
			rz_q    <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
			ez_q    <= '0;
			full_q  <= 1'b0;
			extra_q <= 1'b0;
		end else if (size_wr) begin
			rx_q    <= '0;
			ry_q    <= '0;
			rz_q    <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
			ez_q    <= '0;
			full_q  <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			if (real_push) begin
				if (r_last) begin
					full_q <= 1'b1;
				end
				if (rx_q == sx_q - 1'b1) begin
					rx_q <= '0;
					if (ry_q == sy_q - 1'b1) begin
						ry_q <= '0;
						rz_q <= rz_q + 1'b1;
					end else begin
						ry_q <= ry_q + 1'b1;
					end
				end else begin
					rx_q <= rx_q + 1'b1;
				end
			end
			if (set_extra) begin
				extra_q <= 1'b1;
			end else if (extra_fire) begin
				extra_q <= 1'b0;
			end
			if (emit) begin
				if (e_last) begin
					rx_q   <= '0;
					ry_q   <= '0;
					rz_q   <= '0;
					ex_q   <= '0;
					ey_q   <= '0;
					ez_q   <= '0;
					full_q <= 1'b0;
				end else if (ex_q == sx_q - 1'b1) begin
					ex_q <= '0;
					if (ey_q == sy_q - 1'b1) begin
						ey_q <= '0;
						ez_q <= ez_q + 1'b1;
					end else begin
						ey_q <= ey_q + 1'b1;
					end
				end else begin
					ex_q <= ex_q + 1'b1;
				end
			end
		end
	end

	// Window delay chain, measured from the newest voxel: one row short of a
	// slice, a row less one, two single registers, a row less one, and
	// another slice less a row.
	lsu3_delay #(.ADDR_W(ADDR_A_W)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .push(push), .len(len_a_q), .din(head), .dout(t_a)
	);
	lsu3_delay #(.ADDR_W(ADDR_B_W)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .push(push), .len(len_b_q), .din(t_a), .dout(t_b)
	);
	lsu3_delay #(.ADDR_W(ADDR_B_W)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .push(push), .len(len_b_q), .din(tap_xm_q), .dout(t_c)
	);
	lsu3_delay #(.ADDR_W(ADDR_A_W)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .push(push), .len(len_a_q), .din(t_c), .dout(t_d)
	);

	always_ff @(posedge clk) begin
		if (push) begin
			tap_c_q  <= t_b;
			tap_xm_q <= tap_c_q;
		end
	end

	// Valid bits and the ready chain.
	assign s1_rdy = !v_s1 || s2_rdy;
	assign s2_rdy = !v_s2 || s3_rdy;
	assign s3_rdy = !v_s3 || s4_rdy;
	assign s4_rdy = !v_s4 || sq_in_rdy;
	assign s5_rdy = !v_s5 || s6_rdy;
	assign s6_rdy = !v_s6 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (s1_rdy) v_s1 <= emit;
			if (s2_rdy) v_s2 <= v_s1;
			if (s3_rdy) v_s3 <= v_s2;
			if (s4_rdy) v_s4 <= v_s3;
			if (s5_rdy) v_s5 <= sq_out_vld;
			if (s6_rdy) v_s6 <= v_s5;
		end
	end

	// Stage 1: capture the voxel, its neighbors and which of them lie inside.
	always_ff @(posedge clk) begin
		if (emit) begin
			c_s1              <= tap_c_q;
			nb_s1[lsu3_pkg::NB_XM] <= tap_xm_q;
			nb_s1[lsu3_pkg::NB_XP] <= t_b;
			nb_s1[lsu3_pkg::NB_YM] <= t_c;
			nb_s1[lsu3_pkg::NB_YP] <= t_a;
			nb_s1[lsu3_pkg::NB_ZM] <= t_d;
			nb_s1[lsu3_pkg::NB_ZP] <= head;
			inb_s1[lsu3_pkg::NB_XM] <= (ex_q != '0);
			inb_s1[lsu3_pkg::NB_XP] <= (ex_q != sx_q - 1'b1);
			inb_s1[lsu3_pkg::NB_YM] <= (ey_q != '0);
			inb_s1[lsu3_pkg::NB_YP] <= (ey_q != sy_q - 1'b1);
			inb_s1[lsu3_pkg::NB_ZM] <= (ez_q != '0);
			inb_s1[lsu3_pkg::NB_ZP] <= (ez_q != sz_q - 1'b1);
			dir_s1            <= dir_q;
			last_s1           <= e_last;
		end
	end

	// Upwind terms: backward differences count when their sign matches the
	// front direction, forward differences when it is the opposite.
	always_comb begin
		for (int n = 0; n < NB; n++) begin
			logic signed [lsu3_pkg::DIFF_W-1:0]   d;
			logic signed [2*lsu3_pkg::DIFF_W-1:0] sq;
			logic                                 bwd;
			logic                                 want_pos;
			logic                                 take;
			bwd      = (n % 2) == 0;
			d        = bwd ? (lsu3_pkg::DIFF_W'(c_s1) - lsu3_pkg::DIFF_W'(nb_s1[n]))
			               : (lsu3_pkg::DIFF_W'(nb_s1[n]) - lsu3_pkg::DIFF_W'(c_s1));
			want_pos = bwd ? !dir_s1 : dir_s1;
			take     = inb_s1[n] && (want_pos ? (d > 0) : d[lsu3_pkg::DIFF_W-1]);
			sq       = d * d;
			term_d[n] = take ? sq[lsu3_pkg::TERM_W-1:0] : '0;
		end
	end

	// Stage 2: squared terms.
	always_ff @(posedge clk) begin
		if (s2_rdy && v_s1) begin
			term_s2 <= term_d;
			c_s2    <= c_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: pairwise sums.
	always_ff @(posedge clk) begin
		if (s3_rdy && v_s2) begin
			for (int p = 0; p < NB/2; p++) begin
				psum_s3[p] <= lsu3_pkg::PSUM_W'(term_s2[2*p]) + lsu3_pkg::PSUM_W'(term_s2[2*p+1]);
			end
			c_s3    <= c_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: full sum of squares.
	always_ff @(posedge clk) begin
		if (s4_rdy && v_s3) begin
			sum_s4  <= lsu3_pkg::SUM_W'(psum_s3[0]) + lsu3_pkg::SUM_W'(psum_s3[1])
			         + lsu3_pkg::SUM_W'(psum_s3[2]);
			c_s4    <= c_s3;
			last_s4 <= last_s3;
		end
	end

	assign sq_in_pay.centre = c_s4;
	assign sq_in_pay.last   = last_s4;

	lsu3_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.in_ready(sq_in_rdy),
		.in_radicand(sum_s4),
		.in_pay(sq_in_pay),
		.out_valid(sq_out_vld),
		.out_ready(s5_rdy),
		.out_root(sq_root),
		.out_pay(sq_out_pay)
	);

	// Stage 5: gradient magnitude times the time step.
	always_ff @(posedge clk) begin
		if (s5_rdy && sq_out_vld) begin
			prod_s5 <= lsu3_pkg::PROD_W'(sq_root) * lsu3_pkg::PROD_W'(tstep_q);
			pay_s5  <= sq_out_pay;
		end
	end

	// Subtract, round half up by floor, and saturate.
	always_comb begin
		v_full = (lsu3_pkg::V_W'(pay_s5.centre) <<< lsu3_pkg::STEP_FRAC_BITS)
		       - $signed({2'b00, prod_s5})
		       + $signed(lsu3_pkg::V_W'(1) <<< (lsu3_pkg::STEP_FRAC_BITS - 1));
		q_full = v_full[lsu3_pkg::V_W-1:lsu3_pkg::STEP_FRAC_BITS];
		q_ovf  = (q_full[lsu3_pkg::Q_W-1:PW-1] != '0) && (q_full[lsu3_pkg::Q_W-1:PW-1] != '1);
	end

	// Stage 6: output register.
	always_ff @(posedge clk) begin
		if (s6_rdy && v_s5) begin
			clipped_s6 <= q_ovf;
			last_s6    <= pay_s5.last;
			if (q_ovf) begin
				new_phi_s6 <= q_full[lsu3_pkg::Q_W-1] ? lsu3_pkg::PHI_MIN : lsu3_pkg::PHI_MAX;
			end else begin
				new_phi_s6 <= q_full[PW-1:0];
			end
		end
	end

	assign out_valid  = v_s6;
	assign new_phi    = new_phi_s6;
	assign clipped    = clipped_s6;
	assign last_voxel = last_s6;

endmodule
`default_nettype wire

// ===== rtl/lsu3_checker.sv =====
`default_nettype none
// Port-level checks for the level-set update core.
module lsu3_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_write,
	input wire logic [lsu3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input wire logic [lsu3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic signed [lsu3_pkg::PHI_W-1:0]  phi_value,
	input wire logic                               drain,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [lsu3_pkg::PHI_W-1:0]  new_phi,
	input wire logic                               clipped,
	input wire logic                               last_voxel
);

	// The input is closed in the cycle after each register write.
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !in_ready)
		else $error("input accepted right after a configuration write");

	// A saturated result sits on one of the range bounds.
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			(new_phi == lsu3_pkg::PHI_MAX) || (new_phi == lsu3_pkg::PHI_MIN))
		else $error("clipped result is not a range bound");

	// A stalled result keeps its payload until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_phi) &&
			$stable(clipped) && $stable(last_voxel))
		else $error("stalled result changed");

endmodule

bind level_set_upwind_update_3d_core lsu3_checker u_lsu3_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

	localparam int PW          = lsu3_pkg::PHI_W;
	localparam int WIN_DEPTH   = 2 * lsu3_pkg::DEF_MAX_SIZE_X * lsu3_pkg::DEF_MAX_SIZE_Y + 1;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RAND_VOXELS = 250;

	typedef struct {
		logic signed [PW-1:0] phi;
		bit                   clip;
		bit                   last;
	} voxel_result_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_write;
	logic [lsu3_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [lsu3_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [PW-1:0]                 phi_value;
	logic                                 drain;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [PW-1:0]                 new_phi;
	logic                                 clipped;
	logic                                 last_voxel;

	level_set_upwind_update_3d_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.phi_value  (phi_value),
		.drain      (drain),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.new_phi    (new_phi),
		.clipped    (clipped),
		.last_voxel (last_voxel)
	);

	// Predictor state: the voxel window, stream position and register copies.
	int                               win_mem [WIN_DEPTH];
	longint                           voxels_in;
	longint                           pos_x, pos_y, pos_z;
	bit [lsu3_pkg::SIZE_W-1:0]        reg_sx, reg_sy, reg_sz;
	bit [lsu3_pkg::STEP_W-1:0]        reg_step;
	bit                               reg_front;

	voxel_result_t   pending_phi [$];
	int              err_count;
	int              voxel_count;
	int              result_count;
	int              clip_count;
	int              volume_count;
	int              snd_idle_pct;
	int              rcv_stall_pct;
	longint          cycle_count = 0;

	// Clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint eff_size(input bit [lsu3_pkg::SIZE_W-1:0] v, input int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic longint upwind_sq(input longint d, input bit want_pos);
		if (want_pos ? (d > 0) : (d < 0)) return d * d;
		return 0;
	endfunction

	// Truncated integer square root, one result bit per pass.
	function automatic longint int_root(input longint v);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v)
				r = r | (longint'(1) << b);
		end
		return r;
	endfunction

	function automatic int win_rd(input longint idx);
		return win_mem[idx % WIN_DEPTH];
	endfunction

	// Advances the predictor by one accepted item; returns 1 when a voxel is due.
	function automatic bit update_voxel(input logic signed [PW-1:0] phi, input bit drn,
			output voxel_result_t r);
		longint sx, sy, sz, slice, total, e, need, c, sum, prod, v, q;
		bit     neg;
		sx    = eff_size(reg_sx, lsu3_pkg::DEF_MAX_SIZE_X);
		sy    = eff_size(reg_sy, lsu3_pkg::DEF_MAX_SIZE_Y);
		sz    = eff_size(reg_sz, lsu3_pkg::DEF_MAX_SIZE_Z);
		slice = sx * sy;
		total = slice * sz;
		neg   = reg_front;
		sum   = 0;
		r     = '{default: 0};
		if (!drn && voxels_in < total) begin
			win_mem[voxels_in % WIN_DEPTH] = int'(phi);
			voxels_in++;
		end
		e    = (pos_z * sy + pos_y) * sx + pos_x;
		need = e + slice + 1;
		if (need > total) need = total;
		if (e >= total || voxels_in < need) return 0;

		c = win_rd(e);
		if (pos_x > 0)      sum += upwind_sq(c - win_rd(e - 1), !neg);
		if (pos_x + 1 < sx) sum += upwind_sq(win_rd(e + 1) - c, neg);
		if (pos_y > 0)      sum += upwind_sq(c - win_rd(e - sx), !neg);
		if (pos_y + 1 < sy) sum += upwind_sq(win_rd(e + sx) - c, neg);
		if (pos_z > 0)      sum += upwind_sq(c - win_rd(e - slice), !neg);
		if (pos_z + 1 < sz) sum += upwind_sq(win_rd(e + slice) - c, neg);

		// Step along the gradient magnitude, round half up, then saturate.
		prod = int_root(sum) * longint'(reg_step);
		v    = c * (longint'(1) << lsu3_pkg::STEP_FRAC_BITS) - prod
			+ (longint'(1) << (lsu3_pkg::STEP_FRAC_BITS - 1));
		q    = v >>> lsu3_pkg::STEP_FRAC_BITS;
		if (q > longint'(lsu3_pkg::PHI_MAX)) begin
			q = lsu3_pkg::PHI_MAX;
			r.clip = 1;
		end
		if (q < longint'(lsu3_pkg::PHI_MIN)) begin
			q = lsu3_pkg::PHI_MIN;
			r.clip = 1;
		end
		r.phi  = q[PW-1:0];
		r.last = (e + 1 == total);

		if (r.last) begin
			voxels_in = 0;
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
		end else begin
			pos_x++;
			if (pos_x >= sx) begin
				pos_x = 0;
				pos_y++;
				if (pos_y >= sy) begin
					pos_y = 0;
					pos_z++;
				end
			end
		end
		return 1;
	endfunction

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Receiver backpressure.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// Compare each result transfer with the oldest predicted voxel.
	always @(posedge clk) begin
		voxel_result_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_phi.size() == 0) begin
				$error("unexpected result: new_phi %0d", new_phi);
				err_count++;
			end else begin
				exp_v = pending_phi.pop_front();
				result_count++;
				if (exp_v.clip) clip_count++;
				if (new_phi !== exp_v.phi) begin
					$error("new_phi: expected %0d, actual %0d", exp_v.phi, new_phi);
					err_count++;
				end
				if (clipped !== exp_v.clip) begin
					$error("clipped: expected %0d, actual %0d", exp_v.clip, clipped);
					err_count++;
				end
				if (last_voxel !== exp_v.last) begin
					$error("last_voxel: expected %0d, actual %0d", exp_v.last, last_voxel);
					err_count++;
				end
			end
		end
	end

	// Sends one item; the predictor runs at the edge of its transfer.
	task automatic send_item(input logic signed [PW-1:0] phi, input bit drn);
		voxel_result_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		phi_value <= phi;
		drain     <= drn;
		do @(posedge clk); while (!in_ready);
		if (!drn) voxel_count++;
		if (update_voxel(phi, drn, r)) pending_phi.push_back(r);
		@(negedge clk);
	endtask

	// Holds the sender until every predicted voxel has come, then lets the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_phi.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input lsu3_pkg::cfg_reg_t idx, input int unsigned val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[lsu3_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			lsu3_pkg::REG_SIZE_X:    reg_sx = val[lsu3_pkg::SIZE_W-1:0];
			lsu3_pkg::REG_SIZE_Y:    reg_sy = val[lsu3_pkg::SIZE_W-1:0];
			lsu3_pkg::REG_SIZE_Z:    reg_sz = val[lsu3_pkg::SIZE_W-1:0];
			lsu3_pkg::REG_TIME_STEP: reg_step = val[lsu3_pkg::STEP_W-1:0];
			lsu3_pkg::REG_FRONT_DIR: reg_front = val[0];
			default: ;
		endcase
		if (idx == lsu3_pkg::REG_SIZE_X || idx == lsu3_pkg::REG_SIZE_Y ||
				idx == lsu3_pkg::REG_SIZE_Z) begin
			voxels_in = 0;
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
		end
	endtask

	task automatic set_volume(input int sx, input int sy, input int sz, input int step,
			input bit front);
		wait_idle();
		write_reg(lsu3_pkg::REG_SIZE_X, sx);
		write_reg(lsu3_pkg::REG_SIZE_Y, sy);
		write_reg(lsu3_pkg::REG_SIZE_Z, sz);
		write_reg(lsu3_pkg::REG_TIME_STEP, step);
		write_reg(lsu3_pkg::REG_FRONT_DIR, front);
	endtask

	function automatic logic signed [PW-1:0] pick_phi(input int style, input longint i);
		case (style)
			0: return PW'($urandom);
			1: return PW'(i * 300 - 2000 + $signed($urandom_range(64)) - 32);
			2: return ($urandom_range(1) != 0) ? lsu3_pkg::PHI_MAX : lsu3_pkg::PHI_MIN;
			default: return PW'($signed($urandom_range(4096)) - 2048);
		endcase
	endfunction

	// Streams one volume; the flush uses drains, or ignored voxels when excess is set.
	task automatic run_volume(input int style, input int noise_pct, input bit excess);
		longint total;
		total = eff_size(reg_sx, lsu3_pkg::DEF_MAX_SIZE_X)
			* eff_size(reg_sy, lsu3_pkg::DEF_MAX_SIZE_Y)
			* eff_size(reg_sz, lsu3_pkg::DEF_MAX_SIZE_Z);
		for (longint i = 0; i < total; i++) begin
			if ($urandom_range(99) < noise_pct) send_item(PW'($urandom), 1'b1);
			send_item(pick_phi(style, i), 1'b0);
		end
		while (voxels_in != 0) send_item(PW'($urandom), !excess);
		volume_count++;
	endtask

	task automatic test_small_cube();
		set_volume(2, 2, 2, lsu3_pkg::DEF_TIME_STEP, 1'b0);
		send_item(lsu3_pkg::PHI_MAX, 1'b0);
		send_item(lsu3_pkg::PHI_MIN, 1'b0);
		send_item(PW'(0), 1'b0);
		send_item(PW'(-1), 1'b0);
		send_item(PW'(1), 1'b1);
		send_item(lsu3_pkg::PHI_MIN, 1'b0);
		send_item(lsu3_pkg::PHI_MAX, 1'b0);
		send_item(PW'(256), 1'b0);
		send_item(PW'(-256), 1'b0);
		while (voxels_in != 0) send_item(PW'(0), 1'b1);
	endtask

	task automatic test_negative_front_full_step();
		set_volume(2, 2, 2, 16'hFFFF, 1'b1);
		run_volume(2, 0, 1'b0);
	endtask

	// A size of zero acts as one; zero step leaves phi unchanged.
	task automatic test_unit_volume();
		set_volume(0, 0, 0, 0, 1'b0);
		send_item(lsu3_pkg::PHI_MIN, 1'b0);
		send_item(lsu3_pkg::PHI_MAX, 1'b0);
		send_item(PW'(5), 1'b1);
	endtask

	// Voxels beyond the volume are dropped while the last slice drains.
	task automatic test_excess_voxels();
		set_volume(3, 1, 2, 4096, 1'b0);
		run_volume(0, 0, 1'b1);
	endtask

	// A size write in the middle of a volume restarts the stream.
	task automatic test_restart();
		set_volume(2, 2, 3, 1000, 1'b1);
		repeat (6) send_item(PW'($urandom), 1'b0);
		set_volume(2, 1, 2, 1000, 1'b0);
		run_volume(1, 0, 1'b0);
	endtask

	// Oversized row register acts as the maximum row length.
	task automatic test_long_row();
		set_volume(lsu3_pkg::SIZE_LIMIT, 1, 1, 16'hFFFF, 1'b0);
		run_volume(3, 0, 1'b0);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int quota);
		int target;
		int sx, sy, sz, step;
		target        = voxel_count + quota;
		snd_idle_pct  = idle_pct;
		rcv_stall_pct = stall_pct;
		while (voxel_count < target) begin
			sx = ($urandom_range(19) == 0) ? int'($urandom_range(lsu3_pkg::SIZE_LIMIT))
				: int'($urandom_range(6));
			sy = (sx > 8) ? int'($urandom_range(1)) : int'($urandom_range(5));
			sz = (sx > 8) ? int'($urandom_range(2)) : int'($urandom_range(4));
			case ($urandom_range(5))
				0:       step = 0;
				1:       step = 16'hFFFF;
				default: step = int'($urandom_range(16'hFFFF));
			endcase
			set_volume(sx, sy, sz, step, 1'($urandom_range(1)));
			run_volume(int'($urandom_range(3)), ($urandom_range(4) == 0) ? 15 : 0,
				$urandom_range(4) == 0);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = lsu3_pkg::REG_SIZE_X;
		cfg_data      = '0;
		in_valid      = 1'b0;
		phi_value     = '0;
		drain         = 1'b0;
		out_ready     = 1'b0;
		err_count     = 0;
		voxel_count   = 0;
		result_count  = 0;
		clip_count    = 0;
		volume_count  = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		voxels_in     = 0;
		pos_x         = 0;
		pos_y         = 0;
		pos_z         = 0;
		reg_sx        = lsu3_pkg::DEF_SIZE;
		reg_sy        = lsu3_pkg::DEF_SIZE;
		reg_sz        = lsu3_pkg::DEF_SIZE;
		reg_step      = lsu3_pkg::DEF_TIME_STEP;
		reg_front     = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_small_cube();
		test_negative_front_full_step();
		test_unit_volume();
		test_excess_voxels();
		test_restart();
		test_long_row();
		test_random_phase(0, 0, RAND_VOXELS / 4);
		test_random_phase(71, 0, RAND_VOXELS / 4);
		test_random_phase(0, 71, RAND_VOXELS / 4);
		test_random_phase(26, 26, RAND_VOXELS / 4);

		in_valid <= 1'b0;
		while (pending_phi.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("Covered %0d volumes, %0d voxels in, %0d results checked (%0d saturated).",
			volume_count, voxel_count, result_count, clip_count);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lsu3_pkg.sv
rtl/lsu3_delay.sv
rtl/lsu3_isqrt.sv
rtl/level_set_upwind_update_3d_core.sv
rtl/lsu3_checker.sv
tb/sv/testbench.sv
